// ----- rtl/msdv_pkg.sv -----
package msdv_pkg;

   // Fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int MEAN_W   = 24;
   localparam int STD_W    = 23;
   localparam int VAR_W    = 38;
   localparam int CNT_W    = 5;

   // Fraction bits of the scaled variance that feeds the root (twice the output's 8)
   localparam int V16_FRAC = 16;
   localparam int MEAN_FRAC = 8;
   localparam int VAR_SHIFT = 8;

   // Quotient bits: the scaled variance stays below 2**46, the scaled mean below 2**24
   localparam int QUO_W  = 47;
   // Root bits: the root of a value below 2**48
   localparam int ROOT_W = 24;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       is_last;
   } req_type;

   typedef struct packed {
      logic signed [MEAN_W-1:0] mean;
      logic [STD_W-1:0]         std_dev;
      logic [VAR_W-1:0]         variance;
      logic [CNT_W-1:0]         sample_count;
      logic                     overflowed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MEAN_START,
      ST_PASS,
      ST_VAR_START,
      ST_VAR_WAIT,
      ST_SQRT_START,
      ST_SQRT_WAIT,
      ST_EMIT
   } state_type;

   typedef enum logic {
      DIV_MEAN,
      DIV_VAR
   } div_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        load;
      logic        pass_start;
      logic        pass_run;
      logic        div_start;
      div_sel_type div_sel;
      logic        cap_mean;
      logic        cap_var;
      logic        sqrt_start;
      logic        clear_batch;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic reads_done;
      logic pipe_busy;
      logic div_busy;
      logic sqrt_busy;
   } stat_type;

endpackage

// ----- rtl/msdv_div.sv -----
module msdv_div #(
   parameter int DVW = 63,
   parameter int DSW = 15,
   parameter int QB  = 47
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [DSW-1:0] divisor,
   output logic           busy,
   output logic [QB-1:0]  quotient
);

   localparam int CW = $clog2(QB + 1);

   logic [DSW-1:0] rem_ff, rem_in;
   logic [QB-1:0]  quo_ff, quo_in;
   logic [DSW-1:0] dsr_ff;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;

   logic [DSW:0]   trial;
   logic [DSW:0]   diff;
   logic           take;

   // One quotient bit per cycle, restoring form; quotient shifts in behind the dividend bits
   assign trial = {rem_ff, quo_ff[QB-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign take  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QB);
         rem_in  = dividend[QB+DSW-1:QB];
         quo_in  = dividend[QB-1:0];
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
         rem_in = take ? diff[DSW-1:0] : trial[DSW-1:0];
         quo_in = {quo_ff[QB-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/msdv_sqrt.sv -----
module msdv_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [2*msdv_pkg::ROOT_W-1:0] radicand,
   output logic                          busy,
   output logic [msdv_pkg::ROOT_W-1:0]   root
);

   localparam int RW = msdv_pkg::ROOT_W;
   localparam int CW = $clog2(RW + 1);

   logic [2*RW-1:0] rad_ff, rad_in;
   logic [RW:0]     rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in;

   logic [RW+2:0]   trial_rem;
   logic [RW+2:0]   trial;
   logic [RW+2:0]   diff;
   logic            take;

   // Two radicand bits per cycle, one root bit out
   assign trial_rem = {rem_ff, rad_ff[2*RW-1:2*RW-2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign diff      = trial_rem - trial;
   assign take      = (trial_rem >= trial);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(RW);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
         rad_in  = {rad_ff[2*RW-3:0], 2'b00};
         rem_in  = take ? diff[RW:0] : trial_rem[RW:0];
         root_in = {root_ff[RW-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ----- rtl/msdv_datapath.sv -----
module msdv_datapath #(
   parameter int MAX_SAMPLES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  msdv_pkg::req_type   req,
   input  msdv_pkg::cmd_type   cmd,
   output msdv_pkg::stat_type  stat,
   output msdv_pkg::rsp_type   rsp
);

   localparam int NW  = $clog2(MAX_SAMPLES + 1);
   localparam int IW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int SW  = NW + 16;          // running sum, signed
   localparam int PW  = NW + 17;          // n * x, signed
   localparam int DW  = NW + 18;          // n * x - S, signed
   localparam int AW  = NW + 16;          // |n * x - S|
   localparam int ACW = 3 * NW + 32;      // sum of squared deviations
   localparam int DSW = 3 * NW;           // n cubed
   localparam int DVW = ACW + msdv_pkg::V16_FRAC;
   localparam int QB  = msdv_pkg::QUO_W;
   localparam int RW  = msdv_pkg::ROOT_W;

   // Batch state
   logic [NW-1:0]          count_ff, count_in;
   logic signed [SW-1:0]   sum_ff, sum_in;
   logic                   drop_ff, drop_in;

   // Sample store
   logic signed [msdv_pkg::SAMPLE_W-1:0] store [MAX_SAMPLES];
   logic signed [msdv_pkg::SAMPLE_W-1:0] rd_data_ff;

   // Second pass
   logic [NW-1:0]          rd_cnt_ff, rd_cnt_in;
   logic                   rd_go;
   logic [3:0]             vld_ff;
   logic signed [PW-1:0]   prod_ff;
   logic signed [DW-1:0]   dev;
   logic [AW-1:0]          adev_ff;
   logic [2*AW-1:0]        sq_ff;
   logic [ACW-1:0]         acc_ff;

   // Powers of n
   logic [2*NW-1:0]        n2_ff;
   logic [DSW-1:0]         n3_ff;

   // Shared divider and root
   logic [SW-1:0]          abs_sum;
   logic [DVW-1:0]         div_dividend;
   logic [DSW-1:0]         div_divisor;
   logic                   div_busy;
   logic [QB-1:0]          quotient;
   logic                   sqrt_busy;
   logic [RW-1:0]          root;

   // Results
   logic signed [msdv_pkg::MEAN_W-1:0] mean_ff;
   logic [msdv_pkg::VAR_W-1:0]         var_ff;
   logic [msdv_pkg::MEAN_W-1:0]        mean_mag;

   // Batch loading and clearing
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      drop_in  = drop_ff;
      if (cmd.clear_batch) begin
         count_in = '0;
         sum_in   = '0;
         drop_in  = 1'b0;
      end else if (cmd.load) begin
         if (count_ff < NW'(MAX_SAMPLES)) begin
            count_in = count_ff + 1'b1;
            sum_in   = sum_ff + SW'(req.sample);
         end else begin
            drop_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         drop_ff  <= drop_in;
      end
   end

   // Store write on load, registered read during the pass
   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < NW'(MAX_SAMPLES))) begin
         store[count_ff[IW-1:0]] <= req.sample;
      end
      if (rd_go) begin
         rd_data_ff <= store[rd_cnt_ff[IW-1:0]];
      end
   end

   // Read address counter
   assign rd_go = cmd.pass_run && (rd_cnt_ff != count_ff);

   always_comb begin
      rd_cnt_in = rd_cnt_ff;
      if (cmd.pass_start) begin
         rd_cnt_in = '0;
      end else if (rd_go) begin
         rd_cnt_in = rd_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff <= '0;
         vld_ff    <= '0;
      end else begin
         rd_cnt_ff <= rd_cnt_in;
         vld_ff    <= {vld_ff[2:0], rd_go};
      end
   end

   // Deviation pipeline: n*x, minus S and abs, square, accumulate
   assign dev = DW'(prod_ff) - DW'(sum_ff);

   always_ff @(posedge clock) begin
      prod_ff <= $signed({1'b0, count_ff}) * rd_data_ff;
      adev_ff <= dev[DW-1] ? AW'(-dev) : AW'(dev);
      sq_ff   <= adev_ff * adev_ff;
      if (cmd.pass_start) begin
         acc_ff <= '0;
      end else if (vld_ff[3]) begin
         acc_ff <= acc_ff + ACW'(sq_ff);
      end
   end

   // n squared, then n cubed; count holds still for the whole pass
   always_ff @(posedge clock) begin
      n2_ff <= count_ff * count_ff;
      n3_ff <= n2_ff * count_ff;
   end

   // Divider operands: |S|*256 / n for the mean, acc*65536 / n^3 for the variance
   assign abs_sum = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);

   always_comb begin
      if (cmd.div_sel == msdv_pkg::DIV_MEAN) begin
         div_dividend = DVW'({abs_sum, {msdv_pkg::MEAN_FRAC{1'b0}}});
         div_divisor  = DSW'(count_ff);
      end else begin
         div_dividend = {acc_ff, {msdv_pkg::V16_FRAC{1'b0}}};
         div_divisor  = n3_ff;
      end
   end

   msdv_div #(
      .DVW (DVW),
      .DSW (DSW),
      .QB  (QB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   msdv_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand ((2*RW)'(quotient)),
      .busy     (sqrt_busy),
      .root     (root)
   );

   // Capture the mean (truncated toward zero) and the variance
   assign mean_mag = quotient[msdv_pkg::MEAN_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.cap_mean) begin
         mean_ff <= sum_ff[SW-1] ? $signed(-mean_mag) : $signed(mean_mag);
      end
      if (cmd.cap_var) begin
         var_ff <= quotient[msdv_pkg::VAR_SHIFT+msdv_pkg::VAR_W-1:msdv_pkg::VAR_SHIFT];
      end
   end

   // Status and result
   assign stat.reads_done = (rd_cnt_ff == count_ff);
   assign stat.pipe_busy  = |vld_ff;
   assign stat.div_busy   = div_busy;
   assign stat.sqrt_busy  = sqrt_busy;

   assign rsp.mean         = mean_ff;
   assign rsp.std_dev      = root[msdv_pkg::STD_W-1:0];
   assign rsp.variance     = var_ff;
   assign rsp.sample_count = msdv_pkg::CNT_W'(count_ff);
   assign rsp.overflowed   = drop_ff;

endmodule

// ----- rtl/msdv_ctrl.sv -----
module msdv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                is_last,
   input  msdv_pkg::stat_type  stat,
   output msdv_pkg::cmd_type   cmd,
   output logic                busy,
   output logic                rsp_strobe
);

   msdv_pkg::state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msdv_pkg::ST_LOAD: begin
            if (start && is_last) begin
               state_in = msdv_pkg::ST_MEAN_START;
            end
         end
         msdv_pkg::ST_MEAN_START: begin
            state_in = msdv_pkg::ST_PASS;
         end
         msdv_pkg::ST_PASS: begin
            if (stat.reads_done && !stat.pipe_busy && !stat.div_busy) begin
               state_in = msdv_pkg::ST_VAR_START;
            end
         end
         msdv_pkg::ST_VAR_START: begin
            state_in = msdv_pkg::ST_VAR_WAIT;
         end
         msdv_pkg::ST_VAR_WAIT: begin
            if (!stat.div_busy) begin
               state_in = msdv_pkg::ST_SQRT_START;
            end
         end
         msdv_pkg::ST_SQRT_START: begin
            state_in = msdv_pkg::ST_SQRT_WAIT;
         end
         msdv_pkg::ST_SQRT_WAIT: begin
            if (!stat.sqrt_busy) begin
               state_in = msdv_pkg::ST_EMIT;
            end
         end
         msdv_pkg::ST_EMIT: begin
            state_in = msdv_pkg::ST_LOAD;
         end
         default: begin
            state_in = msdv_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msdv_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      cmd.div_sel = msdv_pkg::DIV_MEAN;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         msdv_pkg::ST_LOAD: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         msdv_pkg::ST_MEAN_START: begin
            // mean division runs alongside the deviation pass
            cmd.pass_start = 1'b1;
            cmd.div_start  = 1'b1;
         end
         msdv_pkg::ST_PASS: begin
            cmd.pass_run = 1'b1;
         end
         msdv_pkg::ST_VAR_START: begin
            cmd.cap_mean  = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = msdv_pkg::DIV_VAR;
         end
         msdv_pkg::ST_VAR_WAIT: begin
            cmd.div_sel = msdv_pkg::DIV_VAR;
         end
         msdv_pkg::ST_SQRT_START: begin
            cmd.cap_var    = 1'b1;
            cmd.sqrt_start = 1'b1;
         end
         msdv_pkg::ST_SQRT_WAIT: begin
            cmd.div_sel = msdv_pkg::DIV_VAR;
         end
         msdv_pkg::ST_EMIT: begin
            rsp_strobe      = 1'b1;
            cmd.clear_batch = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ----- rtl/mean_std_deviation_variance.sv -----
// Channel   Handshake                      Payload
// request   start, busy (taken when        req_item  : sample, is_last
//           start high and busy low)
// response  rsp_strobe, one cycle          rsp_item  : mean, std_dev, variance,
//                                                      sample_count, overflowed
//
// Samples load one per cycle while busy is low. The sample with is_last starts
// the computation: the deviation pass over the store runs next to the mean
// division, then the variance division, the square root and the result strobe
// follow. Busy stays high from the last sample until the result; the mean and
// variance divisions share one divider that gives one quotient bit per cycle.
// Reset is synchronous and clears the batch count, sum and drop flag.
// The result shows for one cycle on rsp_strobe; the receiver cannot stall it.
module mean_std_deviation_variance #(
   parameter int MAX_SAMPLES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  msdv_pkg::req_type  req_item,
   output logic               rsp_strobe,
   output msdv_pkg::rsp_type  rsp_item
);

   msdv_pkg::cmd_type  cmd;
   msdv_pkg::stat_type stat;

   msdv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .is_last    (req_item.is_last),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   msdv_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_item),
      .cmd   (cmd),
      .stat  (stat),
      .rsp   (rsp_item)
   );

endmodule

// ----- tb/sv/mean_std_deviation_variance_check.sv -----
`timescale 1ns / 1ps

module mean_std_deviation_variance_check
   import msdv_pkg::*;
#(
   parameter int MAX_SAMPLES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   output int      fail_count,
   output int      checked_count,
   output int      waiting
);

   // Batch state as the block should hold it
   logic signed [SAMPLE_W-1:0] kept_samples [MAX_SAMPLES];
   int                         kept_count;
   longint                     kept_sum;
   logic                       samples_dropped;

   // Statistics expected from closed batches, oldest first
   rsp_type                    expected_stats [$];
   rsp_type                    want;

   initial begin
      fail_count    = 0;
      checked_count = 0;
      waiting       = 0;
   end

   // Largest r with r*r <= v, one result bit per step
   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = r | (longint'(1) << b);
         if (trial * trial <= v) r = trial;
      end
      return r;
   endfunction

   // Mean, variance and deviation of the stored batch, two-pass, exact integers
   function automatic rsp_type batch_stats();
      rsp_type         res;
      longint          n;
      longint          dev;
      longint          mean_fx;
      longint unsigned n_cubed;
      longint unsigned sum_sq;
      longint unsigned quo;
      longint unsigned rem;
      longint unsigned var_fx;
      longint unsigned var16;
      longint unsigned sd_fx;
      n       = kept_count;
      n_cubed = n * n * n;
      mean_fx = (kept_sum * 256) / n;
      sum_sq  = 0;
      // deviations scaled by n keep the exact mean
      for (int i = 0; i < kept_count; i++) begin
         dev    = n * kept_samples[i] - kept_sum;
         sum_sq += dev * dev;
      end
      quo    = sum_sq / n_cubed;
      rem    = sum_sq % n_cubed;
      var_fx = quo * 256 + (rem * 256) / n_cubed;
      var16  = quo * 65536 + (rem * 65536) / n_cubed;
      sd_fx  = floor_sqrt(var16);
      res.mean         = mean_fx[MEAN_W-1:0];
      res.std_dev      = sd_fx[STD_W-1:0];
      res.variance     = var_fx[VAR_W-1:0];
      res.sample_count = kept_count[CNT_W-1:0];
      res.overflowed   = samples_dropped;
      return res;
   endfunction

   // Store or drop one sample; the last one closes the batch
   task automatic take_sample(input req_type item);
      if (kept_count < MAX_SAMPLES) begin
         kept_samples[kept_count] = item.sample;
         kept_sum   += item.sample;
         kept_count++;
      end else begin
         samples_dropped = 1'b1;
      end
      if (item.is_last) begin
         expected_stats.push_back(batch_stats());
         kept_count      = 0;
         kept_sum        = 0;
         samples_dropped = 1'b0;
      end
   endtask

   task automatic check_field(input string field, input logic signed [63:0] exp_v,
                              input logic signed [63:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", field, exp_v, got_v);
         fail_count++;
      end
   endtask

   // Compare first: a request taken at this edge cannot have its result yet
   always @(posedge clock) begin
      if (reset) begin
         kept_count      = 0;
         kept_sum        = 0;
         samples_dropped = 1'b0;
         expected_stats.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_stats.size() == 0) begin
               $error("result with no batch closed: mean %0d count %0d",
                      rsp_item.mean, rsp_item.sample_count);
               fail_count++;
            end else begin
               want = expected_stats.pop_front();
               check_field("mean", want.mean, rsp_item.mean);
               check_field("std_dev", want.std_dev, rsp_item.std_dev);
               check_field("variance", want.variance, rsp_item.variance);
               check_field("sample_count", want.sample_count, rsp_item.sample_count);
               check_field("overflowed", want.overflowed, rsp_item.overflowed);
               checked_count++;
            end
         end
         if (start && !busy) take_sample(req_item);
      end
      waiting = expected_stats.size();
   end

endmodule

// ----- tb/sv/mean_std_deviation_variance_test.sv -----
`timescale 1ns / 1ps

module mean_std_deviation_variance_test;
   import msdv_pkg::*;

   localparam int DEPTH       = 16;
   localparam int ITEM_TARGET = 1900;
   localparam int QUIET_TAIL  = 200;
   localparam int DRAIN_WAIT  = 300;
   localparam int CYCLE_LIMIT = 1000000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   int      fail_count;
   int      checked_count;
   int      waiting;
   int      items_sent;
   int      batches_sent;
   int      overflow_batches;
   int      cycle_count;

   mean_std_deviation_variance #(.MAX_SAMPLES(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   mean_std_deviation_variance_check #(.MAX_SAMPLES(DEPTH)) checker_i (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .checked_count (checked_count),
      .waiting       (waiting)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Present one sample and hold it until the block takes it
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
      @(negedge clock);
      start    <= 1'b1;
      req_item <= '{sample: smp, is_last: lst};
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // Sender gap; payload wanders while start is low
   task automatic idle_for(input int cycles);
      logic [31:0] junk;
      repeat (cycles) begin
         junk = $urandom;
         @(negedge clock);
         start    <= 1'b0;
         req_item <= junk[SAMPLE_W:0];
      end
   endtask

   // Hold off until every closed batch has reported
   task automatic wait_all_results();
      @(negedge clock);
      start <= 1'b0;
      while (waiting != 0) @(negedge clock);
   endtask

   // Sample shapes: full range, clustered, extremes only, near zero
   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int mode, input int center);
      int v;
      case (mode)
         0: v = $urandom_range(0, 65535);
         1: v = center + $urandom_range(0, 128) - 64;
         2: v = $urandom_range(0, 1) ? 32767 : -32768;
         default: v = $urandom_range(0, 8) - 4;
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d batches still open", cycle_count, waiting);
      $display("status: fail");
      $finish;
   end

   initial begin
      int  mode;
      int  size;
      int  center;
      bit  quiet;
      start            = 1'b0;
      req_item         = '0;
      reset            = 1'b1;
      items_sent       = 0;
      batches_sent     = 0;
      overflow_batches = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: single-sample batches at both extremes, a two-sample spread
      send_sample(16'sh7FFF, 1'b1);
      send_sample(-16'sd32768, 1'b1);
      send_sample(-16'sd32768, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      batches_sent += 3;
      // full store of alternating extremes, then a last sample that is dropped
      for (int k = 0; k < DEPTH; k++) send_sample((k % 2) ? 16'sh7FFF : -16'sd32768, 1'b0);
      send_sample(16'sd0, 1'b1);
      batches_sent++;
      overflow_batches++;
      wait_all_results();

      // Random batches; the tail runs without sender gaps
      while (items_sent < ITEM_TARGET) begin
         mode   = $urandom_range(0, 3);
         center = $urandom_range(0, 60000) - 30000;
         size   = ($urandom_range(0, 5) == 0) ? $urandom_range(DEPTH + 1, DEPTH + 8)
                                              : $urandom_range(1, DEPTH);
         quiet  = (items_sent >= ITEM_TARGET - QUIET_TAIL);
         for (int k = 0; k < size; k++) begin
            send_sample(pick_sample(mode, center), k == size - 1);
            if (!quiet && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 12));
         end
         batches_sent++;
         if (size > DEPTH) overflow_batches++;
         if (!quiet && $urandom_range(0, 15) == 0) wait_all_results();
      end

      wait_all_results();
      // catch any stray result strobe
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d samples in %0d batches, %0d batches overran the store",
               items_sent, batches_sent, overflow_batches);
      $display("compared %0d results over %0d cycles", checked_count, cycle_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
